// ===== hw/rtl/pmpt_pkg.sv =====
// ----------------------------------------------------------------------------
// pmpt_pkg
// shared constants, types and states for the monitored-port peer tracker
// ----------------------------------------------------------------------------
package pmpt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
    localparam int PT_W        = 7;
    localparam int CNT_W       = 64;

    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [15:0] PORT_RESET = 16'd8333;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [FILL_W-1:0] fill_t;
    typedef logic [CNT_W-1:0]  count_t;

    // classification of one input word
    typedef struct packed {
        logic        hit;
        logic        dir;
        logic [31:0] peer;
    } class_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

// ===== hw/rtl/pmpt_if.sv =====
// ----------------------------------------------------------------------------
// pmpt_if
// valid/ready channels for packet summary words and tracker result words
// ----------------------------------------------------------------------------
interface pmpt_in_if;
    logic        valid;
    logic        ready;
    logic        direction;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;

    modport source (output valid, output direction, output ip_protocol,
                    output source_address, output destination_address,
                    output source_port, output destination_port, input ready);
    modport sink   (input valid, input direction, input ip_protocol,
                    input source_address, input destination_address,
                    input source_port, input destination_port, output ready);
endinterface

interface pmpt_out_if;
    logic        valid;
    logic        ready;
    logic        matched;
    logic [31:0] peer_address;
    logic        peer_was_new;
    logic [63:0] inbound_total;
    logic [63:0] outbound_total;
    logic [6:0]  peers_tracked;

    modport source (output valid, output matched, output peer_address,
                    output peer_was_new, output inbound_total,
                    output outbound_total, output peers_tracked, input ready);
    modport sink   (input valid, input matched, input peer_address,
                    input peer_was_new, input inbound_total,
                    input outbound_total, input peers_tracked, output ready);
endinterface

// ===== hw/rtl/port_match_peer_tracker.sv =====
// ----------------------------------------------------------------------------
// port_match_peer_tracker
// counts tcp traffic on a monitored port and tracks remote peers in a table
// ----------------------------------------------------------------------------
// operation: an unmatched word goes straight to the result; a matched word does a linear
//   scan of the valid entries, one read a cycle, then a write if the peer was not found
// flow: one word at a time, taken the cycle after the previous result is loaded
// reset: counters, fill count, replace pointer and control clear at once,
//   monitored port returns to 8333; table contents stay undefined
module port_match_peer_tracker (
    input  logic        clk,
    input  logic        rst_n,
    pmpt_in_if.sink     in_ch,
    pmpt_out_if.source  out_ch,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);
    import pmpt_pkg::*;

    // control and configuration state
    state_t      state_reg, state_next;
    logic [15:0] port_reg;
    fill_t       fill_reg, fill_next;
    addr_t       rp_reg, rp_next;
    count_t      in_count_reg, in_count_next;
    count_t      out_count_reg, out_count_next;
    fill_t       scan_idx_reg, scan_idx_next;
    logic        cmp_valid_reg, cmp_valid_next;
    logic        out_valid_reg, out_valid_next;

    // payload of the word in flight
    class_t      item_reg, item_next;
    logic        fresh_reg, fresh_next;

    // output register payload
    logic        out_matched_reg;
    logic [31:0] out_peer_reg;
    logic        out_new_reg;
    count_t      out_in_total_reg;
    count_t      out_out_total_reg;
    logic [PT_W-1:0] out_tracked_reg;
    logic        out_load;

    class_t      cls;
    logic        issue;
    logic        mem_wr_en;
    addr_t       mem_wr_addr;
    logic [31:0] mem_rd_data;

    pmpt_classify u_classify (
        .direction           (in_ch.direction),
        .ip_protocol         (in_ch.ip_protocol),
        .source_address      (in_ch.source_address),
        .destination_address (in_ch.destination_address),
        .source_port         (in_ch.source_port),
        .destination_port    (in_ch.destination_port),
        .monitored_port      (port_reg),
        .cls                 (cls)
    );

    // a read is issued while the scan index is below the fill count
    assign issue = (state_reg == ST_SCAN) && (scan_idx_reg < fill_reg);

    pmpt_peer_mem u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (item_reg.peer),
        .rd_en   (issue),
        .rd_addr (scan_idx_reg[ADDR_W-1:0]),
        .rd_data (mem_rd_data)
    );

    // append below the fill count, otherwise overwrite at the ring pointer
    assign mem_wr_addr = (fill_reg < FILL_W'(TABLE_DEPTH)) ? fill_reg[ADDR_W-1:0] : rp_reg;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        rp_next        = rp_reg;
        in_count_next  = in_count_reg;
        out_count_next = out_count_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_valid_next = 1'b0;
        item_next      = item_reg;
        fresh_next     = fresh_reg;
        mem_wr_en      = 1'b0;
        out_load       = 1'b0;
        in_ch.ready    = 1'b0;
        out_valid_next = out_valid_reg & ~out_ch.ready;

        case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    item_next     = cls;
                    fresh_next    = 1'b0;
                    scan_idx_next = '0;
                    if (cls.hit)
                    begin
                        if (cls.dir)
                        begin
                            out_count_next = out_count_reg + count_t'(1);
                        end
                        else
                        begin
                            in_count_next = in_count_reg + count_t'(1);
                        end
                        // empty table: nothing to compare against
                        state_next = (fill_reg == '0) ? ST_WRITE : ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_SCAN:
            begin
                // read data arrives the cycle after its index is issued
                cmp_valid_next = issue;
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + fill_t'(1);
                end
                if (cmp_valid_reg && (mem_rd_data == item_reg.peer))
                begin
                    state_next = ST_DONE;
                end
                else if (!issue)
                begin
                    state_next = ST_WRITE;
                end
            end

            ST_WRITE:
            begin
                mem_wr_en  = 1'b1;
                fresh_next = 1'b1;
                if (fill_reg < FILL_W'(TABLE_DEPTH))
                begin
                    fill_next = fill_reg + fill_t'(1);
                end
                else
                begin
                    rp_next = (rp_reg == addr_t'(TABLE_DEPTH - 1)) ? '0 : rp_reg + addr_t'(1);
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            port_reg      <= PORT_RESET;
            fill_reg      <= '0;
            rp_reg        <= '0;
            in_count_reg  <= '0;
            out_count_reg <= '0;
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rp_reg        <= rp_next;
            in_count_reg  <= in_count_next;
            out_count_reg <= out_count_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                port_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        fresh_reg <= fresh_next;
        if (out_load)
        begin
            out_matched_reg   <= item_reg.hit;
            out_peer_reg      <= item_reg.peer;
            out_new_reg       <= fresh_reg;
            out_in_total_reg  <= in_count_reg;
            out_out_total_reg <= out_count_reg;
            out_tracked_reg   <= PT_W'(fill_reg);
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.matched        = out_matched_reg;
    assign out_ch.peer_address   = out_peer_reg;
    assign out_ch.peer_was_new   = out_new_reg;
    assign out_ch.inbound_total  = out_in_total_reg;
    assign out_ch.outbound_total = out_out_total_reg;
    assign out_ch.peers_tracked  = out_tracked_reg;

    // fill count never runs past the table depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(TABLE_DEPTH))
        else $error("peer fill count exceeds table depth");

    // ring pointer moves only once the table is full
    a_rp_full: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(rp_reg) |-> (fill_reg == FILL_W'(TABLE_DEPTH)))
        else $error("replace pointer moved before table filled");

    // a new peer is reported only for a matched word
    a_new_match: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_new_reg) |-> out_matched_reg)
        else $error("new peer reported on unmatched word");

    // table is written only for a matched word that was not found
    a_write_hit: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (item_reg.hit && (state_next == ST_DONE)))
        else $error("table write outside a matched word");

endmodule

// ===== hw/rtl/pmpt_peer_mem.sv =====
// ----------------------------------------------------------------------------
// pmpt_peer_mem
// peer address table, one write port and one registered read port
// ----------------------------------------------------------------------------
module pmpt_peer_mem (
    input  logic            clk,
    input  logic            wr_en,
    input  pmpt_pkg::addr_t wr_addr,
    input  logic [31:0]     wr_data,
    input  logic            rd_en,
    input  pmpt_pkg::addr_t rd_addr,
    output logic [31:0]     rd_data
);
    import pmpt_pkg::*;

    logic [31:0] mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/pmpt_classify.sv =====
// ----------------------------------------------------------------------------
// pmpt_classify
// decides whether a packet summary hits the monitored port, picks the peer
// ----------------------------------------------------------------------------
module pmpt_classify (
    input  logic             direction,
    input  logic [7:0]       ip_protocol,
    input  logic [31:0]      source_address,
    input  logic [31:0]      destination_address,
    input  logic [15:0]      source_port,
    input  logic [15:0]      destination_port,
    input  logic [15:0]      monitored_port,
    output pmpt_pkg::class_t cls
);
    import pmpt_pkg::*;

    logic is_tcp;
    logic dport_hit;
    logic sport_hit;

    assign is_tcp    = (ip_protocol == PROTO_TCP);
    assign dport_hit = (destination_port == monitored_port);
    assign sport_hit = (source_port == monitored_port);

    always_comb
    begin
        cls.dir  = direction;
        cls.hit  = is_tcp & (direction ? (sport_hit | dport_hit) : dport_hit);
        // remote side: source when inbound, destination when outbound
        cls.peer = cls.hit ? (direction ? destination_address : source_address) : 32'd0;
    end

endmodule
